FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion that is
// sampled on the rising clock edge and disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/aip_pkg.sv
// ---------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ASCII integer parser
// Holds the parse phase encoding, field widths, character codes and the
// digit decoder for decimal and hexadecimal text.
// ---------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

	// Field widths
	localparam int CH_W        = 8;
	localparam int VALUE_W     = 32;
	localparam int OFFSET_W    = 16;
	localparam int OUT_TDATA_W = VALUE_W + OFFSET_W;

	// Default saturation limit of the character position
	localparam longint unsigned MAX_OFFSET_DEF = 64'd65535;

	// Character codes
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CH_W-1:0] CH_F_LO  = 8'h66;
	localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CH_W-1:0] CH_F_UP  = 8'h46;
	localparam logic [CH_W-1:0] HEX_LO_BIAS = 8'h57;  // 'a' - 10
	localparam logic [CH_W-1:0] HEX_UP_BIAS = 8'h37;  // 'A' - 10

	// Parse phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SPACE,
		PH_ZERO,
		PH_DIGIT
	} phase_t;

	// Decoded digit
	typedef struct packed {
		logic       valid;
		logic [3:0] val;
	} digit_t;

	// Decode one character as a digit of radix 10 or 16
	function automatic digit_t digit_of(input logic [CH_W-1:0] c, input logic hex);
		digit_t r;
		r.valid = 1'b0;
		r.val   = 4'd0;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			r.valid = 1'b1;
			r.val   = 4'(c - CH_ZERO);
		end else if (hex && (c inside {[CH_A_LO:CH_F_LO]})) begin
			r.valid = 1'b1;
			r.val   = 4'(c - HEX_LO_BIAS);
		end else if (hex && (c inside {[CH_A_UP:CH_F_UP]})) begin
			r.valid = 1'b1;
			r.val   = 4'(c - HEX_UP_BIAS);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ascii_integer_parser.sv
// The character ending the scan is held in the input register; its result is
// loaded into the result register once that register is free. Throughput: one
// character per cycle unless a held result stalls; the single-pass decode and
// the shift-add accumulate sit between the input and result registers.
// Reset (arst_n low, asynchronous): idle phase, accumulator and position
// cleared, decimal mode, both registers empty.
// ---------------------------------------------------------------------------
// ascii_integer_parser: streaming decimal/hex integer parser
// Skips blanks, leading zeros, a hex-mode x prefix (in decimal mode x rejects),
// then accumulates digits modulo 2^32 and reports value and stop offset.
// ---------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser
	import aip_pkg::*;
#(
	parameter longint unsigned MAX_OFFSET = MAX_OFFSET_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration
	input  wire                    cfg_we,
	input  wire                    cfg_wdata,     // hex_mode
	// character stream
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [CH_W-1:0]        s_tdata,       // [7:0] ch
	input  wire                    s_tuser,       // first
	// result stream
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,       // [31:0] value, [47:32] stop_offset
	output logic                   m_tuser        // rejected
);

	localparam int POS_W = $clog2(MAX_OFFSET + 64'd1);
	localparam logic [POS_W-1:0] MAX_POS = MAX_OFFSET[POS_W-1:0];

	// Registers
	logic                valid_s1;
	logic [CH_W-1:0]     ch_s1;
	logic                first_s1;
	logic                hex_mode_q;
	phase_t              phase_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [POS_W-1:0]    pos_q;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                rejected_q;

	// Combinational
	logic                can_load;
	logic                advance;
	phase_t              ph_eff;
	phase_t              phase_d;
	phase_t              digit_next;
	phase_t              zero_next;
	logic [VALUE_W-1:0]  acc_eff;
	logic [VALUE_W-1:0]  acc_d;
	logic [POS_W-1:0]    pos_eff;
	logic [POS_W-1:0]    pos_d;
	logic [POS_W+OFFSET_W-1:0] here_ext;
	logic                is_ws;
	logic                is_zero;
	logic                is_x;
	digit_t              dig;
	logic                step_zero;
	logic                step_digit;
	logic                emit_rej;
	logic                emit_val;

	// Handshake: process the held character when the result register is free
	assign can_load = !out_valid_q || m_tready;
	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q <= 1'b0;
		end else if (cfg_we) begin
			hex_mode_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// Character classes, with a new string restarting the scan
	always_comb begin
		ph_eff   = first_s1 ? PH_SPACE : phase_q;
		acc_eff  = first_s1 ? '0 : acc_q;
		pos_eff  = first_s1 ? '0 : pos_q;
		is_ws    = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB);
		is_zero  = (ch_s1 == CH_ZERO);
		is_x     = (ch_s1 == CH_X_LO) || (ch_s1 == CH_X_UP);
		dig      = digit_of(ch_s1, hex_mode_q);
		here_ext = {{OFFSET_W{1'b0}}, pos_eff};
	end

	// Next phase
	always_comb begin
		digit_next = dig.valid ? PH_DIGIT : PH_IDLE;
		if (is_zero) begin
			zero_next = PH_ZERO;
		end else if (is_x) begin
			zero_next = hex_mode_q ? PH_DIGIT : PH_IDLE;
		end else begin
			zero_next = digit_next;
		end
		case (ph_eff)
			PH_IDLE:  phase_d = PH_IDLE;
			PH_SPACE: phase_d = is_ws ? PH_SPACE : zero_next;
			PH_ZERO:  phase_d = zero_next;
			PH_DIGIT: phase_d = digit_next;
			default:  phase_d = PH_IDLE;
		endcase
	end

	// Accumulate, advance position, decide on a result
	always_comb begin
		step_zero  = ((ph_eff == PH_SPACE) && !is_ws) || (ph_eff == PH_ZERO);
		step_digit = (step_zero && !is_zero && !is_x) || (ph_eff == PH_DIGIT);
		emit_rej   = step_zero && is_x && !hex_mode_q;
		emit_val   = step_digit && !dig.valid;
		acc_d      = acc_eff;
		if (step_digit && dig.valid) begin
			if (hex_mode_q) begin
				acc_d = (acc_eff << 4) + VALUE_W'(dig.val);
			end else begin
				acc_d = (acc_eff << 3) + (acc_eff << 1) + VALUE_W'(dig.val);
			end
		end
		pos_d = pos_eff;
		if ((ph_eff != PH_IDLE) && (pos_eff < MAX_POS)) begin
			pos_d = pos_eff + POS_W'(1);
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= advance && (emit_rej || emit_val);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (emit_rej || emit_val)) begin
			value_q    <= emit_rej ? '0 : acc_eff;
			offset_q   <= emit_rej ? '0 : here_ext[OFFSET_W-1:0];
			rejected_q <= emit_rej;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {offset_q, value_q};
	assign m_tuser  = rejected_q;

endmodule

`default_nettype wire

FILE: rtl/core/aip_checker.sv
// ---------------------------------------------------------------------------
// aip_checker: port-level checks of the ASCII integer parser
// Watches the stream ports for result contents and backpressure behavior.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aip_checker
	import aip_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_TDATA_W-1:0] m_tdata,
	input wire                   m_tuser
);

	// A rejected string carries value and stop offset of zero
	`AST_IMP(a_reject_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// Input side stalls only while a result waits to be taken
	`AST_IMP(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// A held result keeps its contents until transfer
	`AST_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Input is never refused while the result side is free
	`AST_IMP(a_no_idle_stall, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/ascii_integer_parser_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ascii_integer_parser_tb: self-checking bench for the ASCII integer parser
// Streams character strings into the parser in decimal and hex mode and
// checks every reported value, stop offset and reject flag against a
// cycle-free model of the scan. Covers blanks, leading zeros, x prefixes,
// 32-bit wrap, abandoned scans, mode changes inside a string and a long
// output stall that backs up the character stream.
// ---------------------------------------------------------------------------

module ascii_integer_parser_tb;
	import aip_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_G_LO  = 8'h67;
	localparam logic [CH_W-1:0] CH_Z_UP  = 8'h5A;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            first;
	} char_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] stop_offset;
		logic                rejected;
	} parse_result_t;

	// DUT ports
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [CH_W-1:0]        s_tdata   = '0;   // [7:0] ch
	logic                   s_tuser   = 1'b0; // first
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;          // [31:0] value, [47:32] stop_offset
	logic                   m_tuser;          // rejected

	// Stimulus and scoreboard state
	char_item_t    pending_chars[$];
	parse_result_t expected_results[$];
	char_item_t    tx_next;
	bit            tx_taken    = 1'b0;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	bit            rx_hold     = 1'b0;
	bit            hold_go     = 1'b0;
	int            cycles      = 0;
	int            errors      = 0;
	int            chars_in    = 0;
	int            results_out = 0;
	int            rejects     = 0;

	// Scan model state
	phase_t             scan_phase = PH_IDLE;
	logic [VALUE_W-1:0] scan_acc   = '0;
	longint unsigned    scan_pos   = 0;
	logic               mode_hex   = 1'b0;

	ascii_integer_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// Advance the scan model by one character; queue a result when the scan ends
	function automatic void scan_char(input logic [CH_W-1:0] c, input logic first_c);
		longint unsigned here;
		int dig;
		parse_result_t r;
		if (first_c) begin
			scan_phase = PH_SPACE;
			scan_acc   = '0;
			scan_pos   = 0;
		end
		if (scan_phase == PH_IDLE)
			return;
		here = scan_pos;
		if (scan_pos < MAX_OFFSET_DEF)
			scan_pos++;
		if (scan_phase == PH_SPACE) begin
			if (c == CH_SPACE || c == CH_TAB)
				return;
			scan_phase = PH_ZERO;
		end
		if (scan_phase == PH_ZERO) begin
			if (c == CH_ZERO)
				return;
			if (c == CH_X_LO || c == CH_X_UP) begin
				if (!mode_hex) begin
					r.value       = '0;
					r.stop_offset = '0;
					r.rejected    = 1'b1;
					expected_results.push_back(r);
					scan_phase = PH_IDLE;
					return;
				end
				scan_phase = PH_DIGIT;
				return;
			end
			scan_phase = PH_DIGIT;
		end
		dig = -1;
		if (c >= CH_ZERO && c <= CH_NINE)
			dig = int'(c) - int'(CH_ZERO);
		else if (mode_hex && c >= CH_A_LO && c <= CH_F_LO)
			dig = int'(c) - int'(CH_A_LO) + 10;
		else if (mode_hex && c >= CH_A_UP && c <= CH_F_UP)
			dig = int'(c) - int'(CH_A_UP) + 10;
		if (dig >= 0) begin
			scan_acc = scan_acc * (mode_hex ? 32'd16 : 32'd10) + 32'(dig);
			return;
		end
		r.value       = scan_acc;
		r.stop_offset = here[OFFSET_W-1:0];
		r.rejected    = 1'b0;
		expected_results.push_back(r);
		scan_phase = PH_IDLE;
	endfunction

	function automatic void push_char(input logic [CH_W-1:0] c, input logic f);
		char_item_t it;
		it.ch    = c;
		it.first = f;
		pending_chars.push_back(it);
	endfunction

	function automatic logic [CH_W-1:0] pick_digit(input logic hex);
		int v;
		v = hex ? $urandom_range(15) : $urandom_range(9);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return $urandom_range(1) ? CH_A_LO + 8'(v - 10) : CH_A_UP + 8'(v - 10);
	endfunction

	function automatic logic [CH_W-1:0] pick_stop();
		case ($urandom_range(6))
			0: return CH_NUL;
			1: return CH_SPACE;
			2: return CH_COMMA;
			3: return CH_G_LO;
			4: return CH_LF;
			5: return CH_A_LO;
			default: return 8'($urandom);
		endcase
	endfunction

	// Queue one number string; drop the terminator for a broken string unless it has no other character
	function automatic int add_number(input logic hex, input logic ended);
		int n;
		int i;
		bit at_start;
		n = 0;
		at_start = 1'b1;
		if ($urandom_range(1)) begin
			for (i = 0; i < $urandom_range(1, 3); i++) begin
				push_char($urandom_range(1) ? CH_SPACE : CH_TAB, at_start);
				at_start = 1'b0;
				n++;
			end
		end
		for (i = 0; i < $urandom_range(0, 3); i++) begin
			push_char(CH_ZERO, at_start);
			at_start = 1'b0;
			n++;
		end
		if ($urandom_range(99) < (hex ? 40 : 5)) begin
			push_char($urandom_range(1) ? CH_X_LO : CH_X_UP, at_start);
			at_start = 1'b0;
			n++;
		end
		for (i = 0; i < $urandom_range(0, 12); i++) begin
			push_char(pick_digit(hex), at_start);
			at_start = 1'b0;
			n++;
		end
		if (ended || at_start) begin
			push_char(pick_stop(), at_start);
			n++;
		end
		return n;
	endfunction

	// Fill the stream with a mix of numbers, noise and broken strings
	task automatic add_text(input logic hex, input int budget);
		int made;
		int kind;
		int n;
		int i;
		made = 0;
		while (made < budget) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				made += add_number(hex, 1'b1);
			end else if (kind < 85) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					push_char(8'($urandom), 1'b0);
			end else if (kind < 95) begin
				made += add_number(hex, 1'b0);
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					push_char(8'($urandom), i == 0);
				made += n;
			end
		end
	endtask

	task automatic set_radix(input logic hex);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= hex;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_hex = hex;
	endtask

	// Hold until every character is sent and every result has come back
	task automatic wait_drained();
		while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_text(input string s, input logic f);
		int i;
		for (i = 0; i < s.len(); i++)
			push_char(s[i], f && i == 0);
	endfunction

	// Drive the character stream; hold the item until it is taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !tx_taken)) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				tx_next = pending_chars.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= tx_next.ch;
				s_tuser  <= tx_next.first;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Randomize result backpressure
	always @(negedge clk)
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	// Long output stall, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Track character transfers and check each result transfer
	always @(posedge clk) begin
		parse_result_t got;
		parse_result_t want;
		tx_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (tx_taken) begin
				scan_char(s_tdata, s_tuser);
				chars_in++;
			end
			if (m_tvalid && m_tready) begin
				got.value       = m_tdata[VALUE_W-1:0];
				got.stop_offset = m_tdata[VALUE_W +: OFFSET_W];
				got.rejected    = m_tuser;
				results_out++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: expected no result, got value %h offset %0d rejected %b",
						$time, got.value, got.stop_offset, got.rejected);
				end else begin
					want = expected_results.pop_front();
					if (want.rejected)
						rejects++;
					if (got.value !== want.value || got.stop_offset !== want.stop_offset ||
							got.rejected !== want.rejected) begin
						errors++;
						$display({"%0t: mismatch: expected value %h offset %0d rejected %b,",
							" got value %h offset %0d rejected %b"},
							$time, want.value, want.stop_offset, want.rejected,
							got.value, got.stop_offset, got.rejected);
					end
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Test sequence
	initial begin
		int i;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Decimal, slow results
		tx_idle_pct = 6;
		rx_idle_pct = 71;
		set_radix(1'b0);
		push_char(CH_Z_UP, 1'b0);                      // outside any string
		push_char(CH_TAB, 1'b1);
		push_text(" 42", 1'b0);
		push_char(CH_NUL, 1'b0);
		push_text("0x9", 1'b1);                        // rejected, then ignored
		push_text("00 ", 1'b1);                        // zeros then a blank
		push_text("4294967295,", 1'b1);
		push_text("12", 1'b1);                         // abandoned by the next string
		push_text("3;", 1'b1);
		add_text(1'b0, 170);
		push_text("12", 1'b1);                         // left open across the mode change
		wait_drained();

		// Hex, slow results; finish the open string in hex
		set_radix(1'b1);
		push_char(CH_A_LO, 1'b0);
		push_char(CH_NUL, 1'b0);
		push_text("0XfFfFfFfFg", 1'b1);
		push_text("xx", 1'b1);
		push_text("  0x1234567890abcdef", 1'b1);
		push_char(CH_PLUS, 1'b0);
		add_text(1'b1, 170);
		wait_drained();

		// Slow sender
		tx_idle_pct = 71;
		rx_idle_pct = 6;
		set_radix(1'b0);
		add_text(1'b0, 170);
		wait_drained();
		set_radix(1'b1);
		add_text(1'b1, 170);
		wait_drained();

		// No idling: stall the results for a long stretch
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_radix(1'b0);
		hold_go = 1'b1;
		for (i = 0; i < 30; i++)
			void'(add_number(1'b0, 1'b1));
		add_text(1'b0, 80);
		wait_drained();

		set_radix(1'b1);
		add_text(1'b1, 80);
		wait_drained();

		$display("streamed %0d characters in decimal and hex mode, %0d results checked",
			chars_in, results_out);
		$display("%0d rejected prefixes, %0d mismatches", rejects, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
